>>> rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants of the chroma subsample converter: register
// indexes, output mode codes and the item record passed down the pipeline.
// ----------------------------------------------------------------------------
package ccs_pkg;

   // sample and coordinate widths
   localparam int SAMPLE_W    = 8;
   localparam int SUM_W       = 9;               // sum of two samples
   localparam int COORD_W     = 13;              // chroma plane coordinate
   localparam int LINE_DATA_W = 2 * SUM_W;       // cb sum (high), cr sum (low)
   localparam int CSR_DATA_W  = 14;

   typedef logic [1:0]            csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [1:0]            mode_type;
   typedef logic [SAMPLE_W-1:0]   sample_type;
   typedef logic [LINE_DATA_W-1:0] line_data_type;

   // register indexes
   localparam csr_index_type CSR_OUT_MODE     = 2'd0;
   localparam csr_index_type CSR_FRAME_WIDTH  = 2'd1;
   localparam csr_index_type CSR_FRAME_HEIGHT = 2'd2;

   // output modes
   localparam mode_type MODE_444  = 2'd0;
   localparam mode_type MODE_420  = 2'd1;
   localparam mode_type MODE_422  = 2'd2;
   localparam mode_type MODE_RSVD = 2'd3;

   // reset frame size
   localparam csr_data_type RESET_SIZE = 14'd1920;

   // one item in flight; sum_cb/sum_cr hold either the final chroma value
   // (upper bit zero) or the pair sum still waiting for the line store
   typedef struct packed {
      sample_type         luma;
      logic               chroma_valid;
      logic               need_line;
      logic [SUM_W-1:0]   sum_cb;
      logic [SUM_W-1:0]   sum_cr;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               frame_last;
      logic               geometry_error;
   } pipe_item_type;

endpackage

>>> rtl/ccs_line_mem.sv
// ----------------------------------------------------------------------------
// ccs_line_mem
// Line store of per-column pair sums: one port, write or registered read.
// ----------------------------------------------------------------------------
module ccs_line_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic                  rd_en,
   input  logic [AW-1:0]         addr,
   input  ccs_pkg::line_data_type wdata,
   output ccs_pkg::line_data_type rdata
);
   import ccs_pkg::*;

   line_data_type pair_sum_line [DEPTH];
   line_data_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pair_sum_line[addr] <= wdata;
      end
   end

   // registered read, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= pair_sum_line[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/ccs_front.sv
// ----------------------------------------------------------------------------
// ccs_front
// Registers, pixel position counters, held even-column chroma and the
// per-item decode that drives the line store and fills the pipeline item.
// ----------------------------------------------------------------------------
module ccs_front #(
   parameter int MAX_WIDTH  = 8192,
   parameter int MAX_HEIGHT = 8192,
   parameter int AW         = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  ccs_pkg::csr_index_type csr_index,
   input  ccs_pkg::csr_data_type  csr_wdata,
   input  ccs_pkg::sample_type    req_luma,
   input  ccs_pkg::sample_type    req_cb,
   input  ccs_pkg::sample_type    req_cr,
   input  logic                   accept,
   output ccs_pkg::pipe_item_type item,
   output logic                   mem_wr_en,
   output logic                   mem_rd_en,
   output logic [AW-1:0]          mem_addr,
   output ccs_pkg::line_data_type mem_wdata
);
   import ccs_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   mode_type         mode_ff, mode_in;
   csr_data_type     width_ff, width_in;
   csr_data_type     height_ff, height_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [15:0]      held_ff, held_in;

   logic [WW-1:0]    w_eff;
   logic [HW-1:0]    h_eff;
   mode_type         mode_eff;
   logic             geom_err;
   logic [WW:0]      col_plus;
   logic [HW:0]      row_plus;
   logic             last_col;
   logic             last_row;
   logic [SUM_W-1:0] scb;
   logic [SUM_W-1:0] scr;
   logic             csr_hit;

   // clamp frame size to 1..max
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
   end

   // mode and geometry check; reserved mode behaves as 4:4:4
   assign mode_eff = (mode_ff == MODE_RSVD) ? MODE_444 : mode_ff;

   always_comb begin
      case (mode_eff)
         MODE_420: geom_err = w_eff[0] | h_eff[0];
         MODE_422: geom_err = w_eff[0];
         default:  geom_err = 1'b0;
      endcase
   end

   // frame position
   assign col_plus = (WW + 1)'(col_ff) + (WW + 1)'(1);
   assign row_plus = (HW + 1)'(row_ff) + (HW + 1)'(1);
   assign last_col = col_plus >= {1'b0, w_eff};
   assign last_row = row_plus >= {1'b0, h_eff};

   // horizontal pair sums against the held even-column pixel
   assign scb = {1'b0, held_ff[15:8]} + {1'b0, req_cb};
   assign scr = {1'b0, held_ff[7:0]} + {1'b0, req_cr};

   // item decode
   always_comb begin
      item                = '0;
      item.luma           = req_luma;
      item.frame_last     = last_col & last_row;
      item.geometry_error = geom_err;
      held_in             = held_ff;
      mem_wr_en           = 1'b0;
      mem_rd_en           = 1'b0;
      mem_addr            = AW'(col_ff >> 1);
      mem_wdata           = {scb, scr};
      if (!geom_err) begin
         if (mode_eff == MODE_444) begin
            item.chroma_valid = 1'b1;
            item.sum_cb       = {1'b0, req_cb};
            item.sum_cr       = {1'b0, req_cr};
            item.col          = COORD_W'(col_ff);
            item.row          = COORD_W'(row_ff);
         end else if (!col_ff[0]) begin
            held_in = {req_cb, req_cr};
         end else if (mode_eff == MODE_422) begin
            item.chroma_valid = 1'b1;
            item.sum_cb       = {1'b0, scb[SUM_W-1:1]};
            item.sum_cr       = {1'b0, scr[SUM_W-1:1]};
            item.col          = COORD_W'(col_ff >> 1);
            item.row          = COORD_W'(row_ff);
         end else if (!row_ff[0]) begin
            // even row of 4:2:0: park the pair sum
            mem_wr_en = accept;
         end else begin
            // odd row of 4:2:0: fetch the upper pair, finish next stage
            mem_rd_en         = accept;
            item.chroma_valid = 1'b1;
            item.need_line    = 1'b1;
            item.sum_cb       = scb;
            item.sum_cr       = scr;
            item.col          = COORD_W'(col_ff >> 1);
            item.row          = COORD_W'(row_ff >> 1);
         end
      end
   end

   // register writes; any valid index restarts the frame
   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      csr_hit   = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_OUT_MODE: begin
               mode_in = csr_wdata[1:0];
               csr_hit = 1'b1;
            end
            CSR_FRAME_WIDTH: begin
               width_in = csr_wdata;
               csr_hit  = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = csr_wdata;
               csr_hit   = 1'b1;
            end
            default: csr_hit = 1'b0;
         endcase
      end
   end

   // position counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : RW'(row_plus);
         end else begin
            col_in = CW'(col_plus);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_444;
         width_ff  <= RESET_SIZE;
         height_ff <= RESET_SIZE;
         col_ff    <= '0;
         row_ff    <= '0;
         held_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         if (accept) begin
            held_ff <= held_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < w_eff)
      else $error("column counter outside frame width");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("line store read and write in the same cycle");

   a_access_on_accept: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en || mem_rd_en) |-> accept)
      else $error("line store access without an accepted item");
`endif

endmodule

>>> rtl/ccs_back.sv
// ----------------------------------------------------------------------------
// ccs_back
// Line store read stage and output register: completes the 2x2 average
// from the fetched upper pair sum and holds each result item for the sink.
// ----------------------------------------------------------------------------
module ccs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  ccs_pkg::pipe_item_type item,
   input  ccs_pkg::line_data_type mem_rdata,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ccs_pkg::sample_type    rsp_luma_out,
   output logic                   rsp_chroma_valid,
   output ccs_pkg::sample_type    rsp_cb_out,
   output ccs_pkg::sample_type    rsp_cr_out,
   output logic [ccs_pkg::COORD_W-1:0] rsp_chroma_col,
   output logic [ccs_pkg::COORD_W-1:0] rsp_chroma_row,
   output logic                   rsp_frame_last,
   output logic                   rsp_geometry_error
);
   import ccs_pkg::*;

   pipe_item_type  s1_ff;
   logic           s1_valid_ff, s1_valid_in;
   pipe_item_type  out_ff;
   logic           out_valid_ff, out_valid_in;
   pipe_item_type  fin;
   logic           advance;
   logic [SUM_W:0] tot_cb;
   logic [SUM_W:0] tot_cr;

   // output register frees when empty or taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;

   // 2x2 block total, truncating /4
   assign tot_cb = {1'b0, s1_ff.sum_cb} + {1'b0, mem_rdata[LINE_DATA_W-1:SUM_W]};
   assign tot_cr = {1'b0, s1_ff.sum_cr} + {1'b0, mem_rdata[SUM_W-1:0]};

   always_comb begin
      fin = s1_ff;
      if (s1_ff.need_line) begin
         fin.sum_cb    = {1'b0, tot_cb[SUM_W:2]};
         fin.sum_cr    = {1'b0, tot_cr[SUM_W:2]};
         fin.need_line = 1'b0;
      end
   end

   // stage valids
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= item;
      end
      if (advance && s1_valid_ff) begin
         out_ff <= fin;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_luma_out       = out_ff.luma;
   assign rsp_chroma_valid   = out_ff.chroma_valid;
   assign rsp_cb_out         = out_ff.sum_cb[SAMPLE_W-1:0];
   assign rsp_cr_out         = out_ff.sum_cr[SAMPLE_W-1:0];
   assign rsp_chroma_col     = out_ff.col;
   assign rsp_chroma_row     = out_ff.row;
   assign rsp_frame_last     = out_ff.frame_last;
   assign rsp_geometry_error = out_ff.geometry_error;

`ifndef SYNTHESIS
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && req_stall) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("read stage item lost while stalled");

   a_no_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.chroma_valid) |->
      (rsp_cb_out == '0 && rsp_cr_out == '0 && rsp_chroma_col == '0 &&
       rsp_chroma_row == '0))
      else $error("chroma fields not cleared on item without chroma");

   a_err_no_chroma: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.geometry_error) |-> !out_ff.chroma_valid)
      else $error("chroma emitted under geometry error");
`endif

endmodule

>>> rtl/chroma_subsample_converter.sv
// ----------------------------------------------------------------------------
// chroma_subsample_converter
// Raster-order YCbCr 4:4:4 pixels in; luma plus 4:4:4, 4:2:2 or 4:2:0
// chroma out, one result item per pixel.
//
//   channel  prefix  direction  items
//   input    req_    in         pixel: luma, cb, cr
//   result   rsp_    out        luma, chroma pair, chroma position, flags
//   config   csr_    in         write only: out_mode, frame_width, height
//
// One item per cycle sustained while the output is not stalled. At the
// accepting edge the item enters the read stage and the line store is
// accessed; once the output register is free the item moves in and is presented.
// The single line store port serves either the even-row write or
// the odd-row read of an item, never both. Reset is synchronous and clears
// registers and control only; the line store has no clearing pass. A stalled
// output holds its item while one more item may wait in the read stage.
// ----------------------------------------------------------------------------
module chroma_subsample_converter #(
   parameter int MAX_WIDTH  = 8192,
   parameter int MAX_HEIGHT = 8192
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_wr_en,
   input  ccs_pkg::csr_index_type csr_index,
   input  ccs_pkg::csr_data_type  csr_wdata,
   // input items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ccs_pkg::sample_type    req_luma,
   input  ccs_pkg::sample_type    req_cb,
   input  ccs_pkg::sample_type    req_cr,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ccs_pkg::sample_type    rsp_luma_out,
   output logic                   rsp_chroma_valid,
   output ccs_pkg::sample_type    rsp_cb_out,
   output ccs_pkg::sample_type    rsp_cr_out,
   output logic [ccs_pkg::COORD_W-1:0] rsp_chroma_col,
   output logic [ccs_pkg::COORD_W-1:0] rsp_chroma_row,
   output logic                   rsp_frame_last,
   output logic                   rsp_geometry_error
);
   import ccs_pkg::*;

   localparam int DEPTH = MAX_WIDTH / 2;
   localparam int AW    = $clog2(DEPTH);

   logic          accept;
   pipe_item_type item;
   logic          mem_wr_en;
   logic          mem_rd_en;
   logic [AW-1:0] mem_addr;
   line_data_type mem_wdata;
   line_data_type mem_rdata;

   assign accept = req_valid && !req_stall;

   // position, registers and decode
   ccs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .AW         (AW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_luma  (req_luma),
      .req_cb    (req_cb),
      .req_cr    (req_cr),
      .accept    (accept),
      .item      (item),
      .mem_wr_en (mem_wr_en),
      .mem_rd_en (mem_rd_en),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata)
   );

   // pair sum line store
   ccs_line_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_line_mem (
      .clock (clock),
      .wr_en (mem_wr_en),
      .rd_en (mem_rd_en),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // read stage and output register
   ccs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .item               (item),
      .mem_rdata          (mem_rdata),
      .req_stall          (req_stall),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_luma_out       (rsp_luma_out),
      .rsp_chroma_valid   (rsp_chroma_valid),
      .rsp_cb_out         (rsp_cb_out),
      .rsp_cr_out         (rsp_cr_out),
      .rsp_chroma_col     (rsp_chroma_col),
      .rsp_chroma_row     (rsp_chroma_row),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_geometry_error (rsp_geometry_error)
   );

endmodule

>>> tb/tb_chroma_subsample_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chroma_subsample_converter
// Streams raster-order pixels through the chroma subsample converter under
// all output modes and a range of frame sizes, including the clamped and
// odd ones. A built-in predictor of the luma, chroma, position and flag
// outputs checks every result item in order. Both handshakes idle at random,
// and long output holds make the pipe back up into the input.
// ----------------------------------------------------------------------------
module tb_chroma_subsample_converter;
   import ccs_pkg::*;

   localparam int MAX_W       = 8192;
   localparam int MAX_H       = 8192;
   localparam int LINE_SLOTS  = MAX_W / 2;
   localparam int LONG_HOLD   = 100;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PIXELS = 1400;
   localparam int CALM_FROM   = 1200;
   localparam int PRINT_CAP   = 40;

   // index with no register behind it
   localparam csr_index_type CSR_SPARE = 2'd3;

   typedef struct packed {
      sample_type luma;
      sample_type cb;
      sample_type cr;
   } pixel_type;

   typedef struct packed {
      sample_type         luma_out;
      logic               chroma_valid;
      sample_type         cb_out;
      sample_type         cr_out;
      logic [COORD_W-1:0] chroma_col;
      logic [COORD_W-1:0] chroma_row;
      logic               frame_last;
      logic               geometry_error;
   } chroma_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = '0;
   csr_data_type  csr_wdata = '0;

   logic       req_valid = 1'b0;
   logic       req_stall;
   sample_type req_luma = '0;
   sample_type req_cb   = '0;
   sample_type req_cr   = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   sample_type         rsp_luma_out;
   logic               rsp_chroma_valid;
   sample_type         rsp_cb_out;
   sample_type         rsp_cr_out;
   logic [COORD_W-1:0] rsp_chroma_col;
   logic [COORD_W-1:0] rsp_chroma_row;
   logic               rsp_frame_last;
   logic               rsp_geometry_error;

   chroma_subsample_converter DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_luma           (req_luma),
      .req_cb             (req_cb),
      .req_cr             (req_cr),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_luma_out       (rsp_luma_out),
      .rsp_chroma_valid   (rsp_chroma_valid),
      .rsp_cb_out         (rsp_cb_out),
      .rsp_cr_out         (rsp_cr_out),
      .rsp_chroma_col     (rsp_chroma_col),
      .rsp_chroma_row     (rsp_chroma_row),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_geometry_error (rsp_geometry_error)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor state: registers, raster position, held pair, line of sums
   // ------------------------------------------------------------------------
   mode_type     cfg_mode   = MODE_444;
   csr_data_type cfg_width  = RESET_SIZE;
   csr_data_type cfg_height = RESET_SIZE;
   int           col_pos    = 0;
   int           row_pos    = 0;
   sample_type   held_cb    = '0;
   sample_type   held_cr    = '0;
   logic [SUM_W-1:0] line_cb [LINE_SLOTS];
   logic [SUM_W-1:0] line_cr [LINE_SLOTS];

   pixel_type         pixel_queue[$];
   chroma_result_type pending_results[$];

   int  pixels_sent   = 0;
   int  pixels_done   = 0;
   int  chroma_seen   = 0;
   int  frames_seen   = 0;
   int  geom_err_seen = 0;
   int  csr_writes    = 0;
   int  fail_count    = 0;
   int  idle_cycles   = 0;
   int  send_gap      = 0;
   int  stall_left    = 0;
   int  hold_left     = 0;
   int  hold_asks     = 0;
   int  hold_served   = 0;
   logic req_taken    = 1'b0;
   logic calm         = 1'b0;

   function automatic int clamp_size(csr_data_type v, int maxv);
      if (v == 0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   // register write as seen by the predictor; real registers restart the frame
   function automatic void apply_csr(csr_index_type idx, csr_data_type data);
      case (idx)
         CSR_OUT_MODE:     cfg_mode   = data[1:0];
         CSR_FRAME_WIDTH:  cfg_width  = data;
         CSR_FRAME_HEIGHT: cfg_height = data;
         default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
   endfunction

   // one pixel in, one result out; advances the raster position
   function automatic chroma_result_type subsample_pixel(pixel_type px);
      chroma_result_type r;
      int               w;
      int               h;
      int               idx;
      mode_type         m;
      logic             err;
      logic [SUM_W-1:0] sum_cb;
      logic [SUM_W-1:0] sum_cr;
      logic [SUM_W:0]   quad_cb;
      logic [SUM_W:0]   quad_cr;
      r = '0;
      w = clamp_size(cfg_width, MAX_W);
      h = clamp_size(cfg_height, MAX_H);
      m = (cfg_mode == MODE_RSVD) ? MODE_444 : cfg_mode;
      if (m == MODE_420) err = w[0] | h[0];
      else if (m == MODE_422) err = w[0];
      else err = 1'b0;

      r.luma_out       = px.luma;
      r.frame_last     = (col_pos + 1 >= w) && (row_pos + 1 >= h);
      r.geometry_error = err;

      if (!err) begin
         if (m == MODE_444) begin
            r.chroma_valid = 1'b1;
            r.cb_out       = px.cb;
            r.cr_out       = px.cr;
            r.chroma_col   = COORD_W'(col_pos);
            r.chroma_row   = COORD_W'(row_pos);
         end else if (col_pos % 2 == 0) begin
            held_cb = px.cb;
            held_cr = px.cr;
         end else begin
            sum_cb = held_cb + px.cb;
            sum_cr = held_cr + px.cr;
            idx    = (col_pos / 2) % LINE_SLOTS;
            if (m == MODE_422) begin
               r.chroma_valid = 1'b1;
               r.cb_out       = sum_cb[SUM_W-1:1];
               r.cr_out       = sum_cr[SUM_W-1:1];
               r.chroma_col   = COORD_W'(col_pos / 2);
               r.chroma_row   = COORD_W'(row_pos);
            end else if (row_pos % 2 == 0) begin
               line_cb[idx] = sum_cb;
               line_cr[idx] = sum_cr;
            end else begin
               quad_cb        = sum_cb + line_cb[idx];
               quad_cr        = sum_cr + line_cr[idx];
               r.chroma_valid = 1'b1;
               r.cb_out       = quad_cb[SUM_W:2];
               r.cr_out       = quad_cr[SUM_W:2];
               r.chroma_col   = COORD_W'(col_pos / 2);
               r.chroma_row   = COORD_W'(row_pos / 2);
            end
         end
      end

      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      return r;
   endfunction

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         fail_count++;
         if (fail_count <= PRINT_CAP)
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endfunction

   // ------------------------------------------------------------------------
   // monitor: check results, predict accepted items, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      chroma_result_type exp_r;
      logic in_fire;
      logic out_fire;
      in_fire  = req_valid && !req_stall;
      out_fire = rsp_valid && !rsp_stall;
      req_taken <= in_fire && !reset;
      if (!reset) begin
         // result items first, so a result never meets the item taken this edge
         if (out_fire) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= PRINT_CAP)
                  $display("%0t: result item with nothing expected, luma_out %0d",
                           $time, rsp_luma_out);
            end else begin
               exp_r = pending_results.pop_front();
               check_field("luma_out", exp_r.luma_out, rsp_luma_out);
               check_field("chroma_valid", exp_r.chroma_valid, rsp_chroma_valid);
               check_field("cb_out", exp_r.cb_out, rsp_cb_out);
               check_field("cr_out", exp_r.cr_out, rsp_cr_out);
               check_field("chroma_col", exp_r.chroma_col, rsp_chroma_col);
               check_field("chroma_row", exp_r.chroma_row, rsp_chroma_row);
               check_field("frame_last", exp_r.frame_last, rsp_frame_last);
               check_field("geometry_error", exp_r.geometry_error, rsp_geometry_error);
               pixels_done++;
               if (exp_r.chroma_valid) chroma_seen++;
               if (exp_r.frame_last) frames_seen++;
               if (exp_r.geometry_error) geom_err_seen++;
            end
         end
         if (in_fire)
            pending_results.insert(pending_results.size(),
                                   subsample_pixel({req_luma, req_cb, req_cr}));

         if (in_fire || out_fire) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("chroma_subsample_converter: mismatch");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // driver: offer queued pixels, random gaps between items
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      pixel_type px;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            px = pixel_queue.pop_front();
            req_valid <= 1'b1;
            req_luma  <= px.luma;
            req_cb    <= px.cb;
            req_cr    <= px.cr;
            if (!calm && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random stall bursts, plus long holds on request
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_asks != hold_served) begin
         hold_served++;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic write_csr(csr_index_type idx, csr_data_type data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      apply_csr(idx, data);
      csr_writes++;
   endtask

   // all items sent and all results back
   task automatic wait_idle();
      while (pixel_queue.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic start_phase(mode_type m, csr_data_type w, csr_data_type h);
      wait_idle();
      write_csr(CSR_OUT_MODE, csr_data_type'(m));
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
   endtask

   function automatic void push_pixel(sample_type l, sample_type cb, sample_type cr);
      pixel_queue.insert(pixel_queue.size(), pixel_type'({l, cb, cr}));
      pixels_sent++;
   endfunction

   // random sample with a bias toward the extremes
   function automatic sample_type pick_sample();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      return sample_type'($urandom_range(0, 255));
   endfunction

   function automatic void push_random_pixels(int n);
      for (int i = 0; i < n; i++) push_pixel(pick_sample(), pick_sample(), pick_sample());
   endfunction

   initial begin
      int       sel;
      int       w;
      int       h;
      int       n;
      int       phase_no;
      mode_type m;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset settings: passthrough on a 1920 x 1920 frame
      push_pixel(8'd0, 8'd0, 8'd0);
      push_pixel(8'd255, 8'd255, 8'd255);
      push_pixel(8'd128, 8'd1, 8'd254);

      // 2x2 averages at the sample extremes
      start_phase(MODE_420, 14'd4, 14'd2);
      push_pixel(8'd0, 8'd255, 8'd0);
      push_pixel(8'd255, 8'd255, 8'd0);
      push_pixel(8'd1, 8'd0, 8'd255);
      push_pixel(8'd2, 8'd0, 8'd255);
      push_pixel(8'd3, 8'd255, 8'd0);
      push_pixel(8'd4, 8'd255, 8'd0);
      push_pixel(8'd5, 8'd0, 8'd255);
      push_pixel(8'd6, 8'd0, 8'd254);

      // horizontal pair with a truncated odd sum
      start_phase(MODE_422, 14'd2, 14'd1);
      push_pixel(8'd7, 8'd255, 8'd255);
      push_pixel(8'd8, 8'd254, 8'd255);

      // geometry errors: odd width, then odd height
      start_phase(MODE_420, 14'd3, 14'd2);
      push_random_pixels(3);
      start_phase(MODE_420, 14'd2, 14'd3);
      push_random_pixels(2);

      // reserved mode acts as passthrough; zero sizes count as one
      start_phase(MODE_RSVD, 14'd0, 14'd0);
      push_random_pixels(2);

      // a write to the spare index must not restart the frame
      start_phase(MODE_444, 14'd4, 14'd2);
      push_random_pixels(2);
      wait_idle();
      write_csr(CSR_SPARE, 14'h2A55);
      push_random_pixels(2);

      // largest sizes, short stretches only; oversize values clamp
      start_phase(MODE_422, 14'h3FFF, 14'd0);
      push_random_pixels(40);
      start_phase(MODE_420, 14'd8192, 14'd2);
      push_random_pixels(40);
      start_phase(MODE_444, 14'd8192, 14'h3FFF);
      push_random_pixels(40);
      start_phase(MODE_444, 14'd1, 14'h3FFF);
      push_random_pixels(60);

      // random frames, mostly well-formed sizes
      phase_no = 0;
      while (pixels_sent < RANDOM_PIXELS) begin
         sel = $urandom_range(0, 9);
         if (sel < 2) m = MODE_444;
         else if (sel < 6) m = MODE_420;
         else if (sel < 9) m = MODE_422;
         else m = MODE_RSVD;
         w = 2 * $urandom_range(1, 12);
         h = 2 * $urandom_range(1, 4);
         if ($urandom_range(0, 7) == 0) w = $urandom_range(1, 25);
         if ($urandom_range(0, 7) == 0) h = $urandom_range(1, 7);
         n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
         if (n > 160) n = 160;
         if (pixels_sent >= CALM_FROM) calm = 1'b1;
         start_phase(m, csr_data_type'(w), csr_data_type'(h));
         // long output hold: the pipe fills and backs up into the input
         if (!calm && (phase_no == 1 || $urandom_range(0, 15) == 0)) begin
            hold_asks++;
            if (n < 40) n = 40;
         end
         push_random_pixels(n);
         phase_no++;
      end

      wait_idle();
      repeat (6) @(posedge clock);
      $display("checked %0d pixels over %0d register writes: %0d chroma samples,",
               pixels_done, csr_writes, chroma_seen);
      $display("%0d frame ends, %0d pixels flagged with a geometry error",
               frames_seen, geom_err_seen);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("chroma_subsample_converter: match");
      else
         $display("chroma_subsample_converter: mismatch");
      $finish;
   end

endmodule
